// ===== rtl/mvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

  // Widths of the payload fields.
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int PROD_W = 2 * DATA_W;
  // Four products of two signed 32-bit values, plus the rounding constant.
  localparam int ACC_W  = PROD_W + 2;
  localparam int DIM    = 4;

  // 1.0 in Q16.16.
  localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_XFORM4 = 2'd1,
    OP_XFORM3 = 2'd2,
    OP_XFORM2 = 2'd3
  } op_t;

  // One item as it travels down the row of cells.
  typedef struct packed {
    op_t                            op;
    logic [IDX_W-1:0]               idx;
    logic [DATA_W-1:0]              val;
    logic [DIM-1:0][DATA_W-1:0]     vec;
    logic [DIM-1:0][ACC_W-1:0]      acc;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/matrix_vector_transform_4x4.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata (low bit up)                                  tuser
// in_       slave      element_index[3:0] element_value[35:4] vec_x[67:36]  operation[1:0]
//                      vec_y[99:68] vec_z[131:100] vec_w[163:132], pad 0
// out_      master     out_x[31:0] out_y[63:32] out_z[95:64] out_w[127:96]  -
//
// One item is accepted per cycle while in_tready is high. A transform result
// is ready to transfer once it has passed the four column cells of
// two stages each (multiply, then accumulate) and the rounding output
// register. Each cell holds one matrix column, so a load takes effect
// for every item behind it and for none ahead of it.
// Reset (rst_n low, synchronous) empties the pipeline and clears the matrix.
// A stalled output holds its result while the cells behind it keep filling
// until each stage is occupied; only then does in_tready fall.
module matrix_vector_transform_4x4 (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // element_index, element_value, vec_x, vec_y, vec_z, vec_w, zero pad
  input  wire logic [167:0] in_tdata,
  // operation
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_x, out_y, out_z, out_w
  output logic [127:0]      out_tdata
);

  localparam int NCELL = mvt_pkg::DIM;

  mvt_pkg::item_t in_item;
  mvt_pkg::op_t   in_op;
  mvt_pkg::item_t chain_item  [NCELL+1];
  logic           chain_valid [NCELL+1];
  logic           chain_ready [NCELL+1];

  // Unpack the transfer and fill in the implied components: z is 1.0 in the
  // two-component mode, w is 1.0 in every mode but the four-component one.
  always_comb begin
    in_op          = mvt_pkg::op_t'(in_tuser);
    in_item.op     = in_op;
    in_item.idx    = in_tdata[3:0];
    in_item.val    = in_tdata[35:4];
    in_item.vec[0] = in_tdata[67:36];
    in_item.vec[1] = in_tdata[99:68];
    in_item.vec[2] = (in_op == mvt_pkg::OP_XFORM2) ? mvt_pkg::ONE_Q16 : in_tdata[131:100];
    in_item.vec[3] = (in_op == mvt_pkg::OP_XFORM4) ? in_tdata[163:132] : mvt_pkg::ONE_Q16;
    in_item.acc    = '0;
  end

  assign chain_item[0]  = in_item;
  assign chain_valid[0] = in_tvalid;
  assign in_tready      = chain_ready[0];

  // The row of column cells; partial sums move one cell on per two stages.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mvt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .col_id   (2'(i)),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_item  (chain_item[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_item  (chain_item[i+1])
    );
  end

  mvt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (chain_valid[NCELL]),
    .up_ready  (chain_ready[NCELL]),
    .up_item   (chain_item[NCELL]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/mvt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One matrix column. The first stage multiplies the held column by this
// column's vector component; the second adds the products to the partial
// sums that arrive from the previous cell.
module mvt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        col_id,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire mvt_pkg::item_t    up_item,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output mvt_pkg::item_t         dn_item
);

  logic [mvt_pkg::DATA_W-1:0]        col_r [mvt_pkg::DIM];
  logic                              v1_r;
  logic                              v1_nxt;
  mvt_pkg::item_t                    item1_r;
  logic signed [mvt_pkg::PROD_W-1:0] prod_r   [mvt_pkg::DIM];
  logic signed [mvt_pkg::PROD_W-1:0] prod_nxt [mvt_pkg::DIM];
  logic                              v2_r;
  logic                              v2_nxt;
  mvt_pkg::item_t                    item2_r;
  mvt_pkg::item_t                    item2_nxt;
  logic                              en1;
  logic                              en2;
  logic                              load_hit;
  logic signed [mvt_pkg::DATA_W-1:0] vsel;

  always_comb begin
    en2      = !v2_r || dn_ready;
    en1      = !v1_r || en2;
    up_ready = en1;
    v1_nxt   = up_valid;
    v2_nxt   = v1_r;
    load_hit = up_valid && en1 && (up_item.op == mvt_pkg::OP_LOAD)
               && (up_item.idx[3:2] == col_id);
    vsel     = $signed(up_item.vec[col_id]);
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      prod_nxt[r] = $signed(col_r[r]) * vsel;
    end
    item2_nxt = item1_r;
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      item2_nxt.acc[r] = item1_r.acc[r]
                         + {{(mvt_pkg::ACC_W - mvt_pkg::PROD_W){prod_r[r][mvt_pkg::PROD_W-1]}},
                            prod_r[r]};
    end
  end

  // Held column: loads take effect in stream order as they pass this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        col_r[r] <= '0;
      end
    end else if (load_hit) begin
      col_r[up_item.idx[1:0]] <= up_item.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= v1_nxt;
      end
      if (en2) begin
        v2_r <= v2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      item1_r <= up_item;
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        prod_r[r] <= prod_nxt[r];
      end
    end
    if (en2) begin
      item2_r <= item2_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_item  = item2_r;

endmodule

`default_nettype wire

// ===== rtl/mvt_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rounds and saturates the four sums, clears the components that the mode
// does not produce, and holds the result until it is taken. Load items end
// here without a result.
module mvt_out (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  input  wire mvt_pkg::item_t          up_item,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [4*mvt_pkg::DATA_W-1:0] out_data
);

  localparam int SH_W = mvt_pkg::ACC_W - 16;

  logic                                      ov_r;
  logic                                      ov_nxt;
  logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] res_r;
  logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] res_nxt;
  logic                                      en;
  logic [mvt_pkg::ACC_W-1:0]                 rnd [mvt_pkg::DIM];
  logic [SH_W-1:0]                           sh  [mvt_pkg::DIM];
  logic                                      hi_ones  [mvt_pkg::DIM];
  logic                                      hi_zeros [mvt_pkg::DIM];

  always_comb begin
    en       = !ov_r || out_ready;
    up_ready = en;
    ov_nxt   = up_valid && (up_item.op != mvt_pkg::OP_LOAD);
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      // Add half a unit, then drop sixteen fraction bits.
      rnd[r]      = up_item.acc[r] + mvt_pkg::ACC_W'(32'h0000_8000);
      sh[r]       = rnd[r][mvt_pkg::ACC_W-1:16];
      hi_ones[r]  = &sh[r][SH_W-1:mvt_pkg::DATA_W-1];
      hi_zeros[r] = ~|sh[r][SH_W-1:mvt_pkg::DATA_W-1];
      if (hi_ones[r] || hi_zeros[r]) begin
        res_nxt[r] = sh[r][mvt_pkg::DATA_W-1:0];
      end else if (sh[r][SH_W-1]) begin
        res_nxt[r] = 32'h8000_0000;
      end else begin
        res_nxt[r] = 32'h7FFF_FFFF;
      end
    end
    if (up_item.op == mvt_pkg::OP_XFORM2) begin
      res_nxt[2] = '0;
    end
    if (up_item.op != mvt_pkg::OP_XFORM4) begin
      res_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

// ===== rtl/mvt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  // A result that has not been taken stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before transfer");

  // A result that has not been taken keeps its value.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result behind.
  a_reset_empty : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result offered straight after reset");

  // With the output register empty every stage behind it can move.
  a_ready_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

endmodule

bind matrix_vector_transform_4x4 mvt_checker u_mvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== test/matrix_vector_transform_4x4_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the 4x4 matrix-vector transform. The matrix is kept
// here as well: every input transfer is applied to this copy, so a load
// changes it and a transform predicts the four rounded, saturated output
// components. Results are compared in order against the oldest prediction.
module matrix_vector_transform_4x4_tb;
  import mvt_pkg::*;

  // Four Q16.16 components with x in the lowest bits, as out_tdata carries them.
  typedef logic [DIM-1:0][DATA_W-1:0] vec4_t;

  // Holds a copy of the matrix and the transforms still waiting for their result.
  class matrix_transform_model;
    logic signed [DATA_W-1:0] elements [DIM*DIM];
    vec4_t                    pending_results [$];
    int unsigned              mismatches;
    string                    component_names [DIM];

    function new();
      foreach (elements[i]) begin
        elements[i] = '0;
      end
      mismatches = 0;
      component_names = '{"out_x", "out_y", "out_z", "out_w"};
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // The exact sum has 68 bits; half a unit is added before the floor shift,
    // so ties go towards plus infinity, then the value is clamped to 32 bits.
    function logic [DATA_W-1:0] round_saturate(logic signed [ACC_W+1:0] sum);
      logic signed [ACC_W+1:0] shifted;
      shifted = (sum + 68'sd32768) >>> 16;
      if (shifted > 68'sh7FFF_FFFF) begin
        return 32'h7FFF_FFFF;
      end
      if (shifted < -68'sh8000_0000) begin
        return 32'h8000_0000;
      end
      return shifted[DATA_W-1:0];
    endfunction

    // Called for every accepted input transfer.
    function void note_input(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                             vec4_t vec);
      logic signed [DATA_W-1:0] operand [DIM];
      logic signed [PROD_W-1:0] product;
      logic signed [ACC_W+1:0]  sum;
      vec4_t                    result;
      if (op == OP_LOAD) begin
        elements[idx] = val;
        return;
      end
      operand[0] = vec[0];
      operand[1] = vec[1];
      operand[2] = (op == OP_XFORM2) ? ONE_Q16 : vec[2];
      operand[3] = (op == OP_XFORM4) ? vec[3] : ONE_Q16;
      for (int r = 0; r < DIM; r++) begin
        sum = '0;
        for (int c = 0; c < DIM; c++) begin
          product = elements[c*DIM + r] * operand[c];
          sum = sum + product;
        end
        result[r] = round_saturate(sum);
      end
      if (op == OP_XFORM2) begin
        result[2] = '0;
      end
      if (op != OP_XFORM4) begin
        result[3] = '0;
      end
      pending_results.push_back(result);
    endfunction

    // Called for every accepted result transfer.
    function void check_result(vec4_t got);
      vec4_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer %h with no transform outstanding", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      for (int i = 0; i < DIM; i++) begin
        if (got[i] !== want[i]) begin
          $error("%s: expected %h, actual %h", component_names[i], want[i], got[i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic [1:0]   in_tuser = OP_LOAD;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  matrix_transform_model model;

  // Idling percentages of the current phase: chance per cycle that the
  // sender leaves a gap or that the receiver holds off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // The main process raises hold_requests; the receiver process serves each
  // request with one long hold-off that it counts down itself.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned stall_left = 0;

  localparam int unsigned LONG_HOLD = 64;
  localparam int unsigned TAIL_CYCLES = 20;

  matrix_vector_transform_4x4 i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Receiver: checks each result transfer and drives out_tready for the next
  // edge. Values read just after the edge are those the block sampled there.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      model.check_result(out_tdata);
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // A mix of full-range words, small values around zero, the extremes and
  // pure fractions, so that results are not all saturated.
  function automatic logic [DATA_W-1:0] random_q16();
    case ($urandom_range(4))
      0, 1: begin
        return $urandom;
      end
      2: begin
        return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      end
      3: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          3: return ONE_Q16;
          default: return -ONE_Q16;
        endcase
      end
      default: begin
        return $urandom_range(32'h0000_FFFF) ^ {DATA_W{$urandom_range(1) == 1}};
      end
    endcase
  endfunction

  // Offers one item and waits for its transfer. Afterwards the sender may
  // leave a gap; otherwise tvalid stays high for the next item.
  task automatic offer_item(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                            vec4_t vec);
    in_tuser  <= op;
    in_tdata  <= {4'b0, vec[3], vec[2], vec[1], vec[0], val, idx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    model.note_input(op, idx, val, vec);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // A load carries random vector fields, which the block must ignore.
  task automatic load_element(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    offer_item(OP_LOAD, idx, val, {$urandom, $urandom, $urandom, $urandom});
  endtask

  // A transform carries a random index and value, which the block must ignore.
  task automatic run_transform(op_t op, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                               logic [DATA_W-1:0] z, logic [DATA_W-1:0] w);
    offer_item(op, IDX_W'($urandom_range(15)), $urandom, {w, z, y, x});
  endtask

  // The sender stops offering until every outstanding result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned send_pcts [4];
    int unsigned recv_pcts [4];
    send_pcts = '{0, 64, 0, 33};
    recv_pcts = '{0, 0, 64, 33};
    model = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A transform straight after reset sees an all-zero matrix.
    run_transform(OP_XFORM4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    // Diagonal with the extremes: x saturates high, y saturates low, z passes
    // the most negative value unchanged and w is negated.
    load_element(4'd0, 32'h7FFF_FFFF);
    load_element(4'd5, 32'h8000_0000);
    load_element(4'd10, ONE_Q16);
    load_element(4'd15, -ONE_Q16);
    run_transform(OP_XFORM4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    // Smallest raw elements: exact halves round up, just below half rounds down.
    load_element(4'd0, 32'h0000_0001);
    load_element(4'd5, 32'h0000_0001);
    run_transform(OP_XFORM4, 32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0);
    run_transform(OP_XFORM4, 32'h0000_7FFF, 32'hFFFF_7FFF, 32'h0, 32'h0);
    // Fill columns 2 and 3 so that the implied ones of the short modes show.
    load_element(4'd8, ONE_Q16);
    load_element(4'd12, 32'h0002_0000);
    load_element(4'd14, 32'h0001_2345);
    load_element(4'd11, ONE_Q16);
    run_transform(OP_XFORM3, ONE_Q16, ONE_Q16, 32'h0003_0000, $urandom);
    run_transform(OP_XFORM2, ONE_Q16, ONE_Q16, $urandom, $urandom);
    run_transform(OP_XFORM4, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
    // Large w row, so that the sum of several big products saturates.
    load_element(4'd3, 32'h7FFF_FFFF);
    load_element(4'd7, 32'h7FFF_FFFF);
    load_element(4'd15, 32'h7FFF_FFFF);
    run_transform(OP_XFORM4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_transform(OP_XFORM4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    run_transform(OP_XFORM3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, $urandom);
    wait_drained();

    // Random part in four idling phases. A quarter of the items are loads,
    // so the matrix keeps changing under the stream of transforms.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      for (int n = 0; n < 225; n++) begin
        // With no sender gaps in the first phase, a long hold-off fills the
        // pipeline until in_tready falls.
        if (phase == 0 && n == 100) begin
          hold_requests = hold_requests + 1;
        end
        // The sender pauses once mid-phase until the block has emptied.
        if (phase == 2 && n == 100) begin
          wait_drained();
        end
        if ($urandom_range(3) == 0) begin
          load_element(IDX_W'($urandom_range(15)), random_q16());
        end else begin
          run_transform(op_t'($urandom_range(OP_XFORM2, OP_XFORM4)), random_q16(),
                        random_q16(), random_q16(), random_q16());
        end
      end
      wait_drained();
    end

    // Every result has come; allow for anything still moving through the cells.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run time limit, many times the slowest correct run.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
